// File: design/greedy_word_wrap_top_macros.svh
// Assertion macros shared by the checker of the word wrapper.
// No dependencies; included by files that hold concurrent assertions.
`ifndef GREEDY_WORD_WRAP_TOP_MACROS_SVH
`define GREEDY_WORD_WRAP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GWW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("greedy_word_wrap_top: same-cycle port check failed");

// Next-cycle implication, disabled while reset is low.
`define GWW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("greedy_word_wrap_top: next-cycle port check failed");

`endif

// File: design/gww_pkg.sv
// Shared constants of the greedy word wrapper.
// No dependencies; imported by every module of the block.
package gww_pkg;

    localparam int CHAR_W       = 8;
    localparam int CFG_W        = 6;
    localparam int LINE_MAX_DEF = 32;

    localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'd32;
    localparam logic [CFG_W-1:0]  WIDTH_RESET = 6'd32;

endpackage

// File: design/gww_buf.sv
// Line buffer storage: one write port, one read port with registered data.
// Depends on gww_pkg for the character width.
module gww_buf
    import gww_pkg::*;
#(
    parameter int AW = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CHAR_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [CHAR_W-1:0] rd_data
);

    localparam int DEPTH = 1 << AW;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/gww_seq.sv
// Sequencer of the word wrapper: line planning, cut bookkeeping, output stepping.
// Depends on gww_pkg; drives the ports of gww_buf.
module gww_seq
    import gww_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CFG_W-1:0]  cfg_width,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_line_end,
    output logic              out_text_end,
    output logic              buf_wr_en,
    output logic [$clog2(LINE_MAX > 1 ? LINE_MAX : 2)-1:0] buf_wr_addr,
    output logic [CHAR_W-1:0] buf_wr_data,
    output logic              buf_rd_en,
    output logic [$clog2(LINE_MAX > 1 ? LINE_MAX : 2)-1:0] buf_rd_addr,
    input  logic [CHAR_W-1:0] buf_rd_data
);

    localparam int AW = $clog2(LINE_MAX > 1 ? LINE_MAX : 2);
    localparam int CW = $clog2(LINE_MAX + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_APPEND
    } state_t;

    state_t            state_reg,   state_next;
    logic [CW-1:0]     fill_reg,    fill_next;
    logic [AW-1:0]     head_reg,    head_next;
    logic [AW-1:0]     sp_pos_reg,  sp_pos_next;
    logic              sp_seen_reg, sp_seen_next;
    logic [CW-1:0]     active_reg,  active_next;
    logic [CHAR_W-1:0] char_reg,    char_next;
    logic              last_reg,    last_next;
    logic [CW-1:0]     n_reg,       n_next;
    logic [CW-1:0]     idx_reg,     idx_next;
    logic              final_reg,   final_next;
    logic              cut_reg,     cut_next;

    logic [CW-1:0] width_clamp;
    logic [CW-1:0] active_eff;
    logic          line_done;
    logic          is_cut;

    always_comb begin
        if (cfg_width == '0) begin
            width_clamp = CW'(1);
        end else if (cfg_width > CFG_W'(LINE_MAX)) begin
            width_clamp = CW'(LINE_MAX);
        end else begin
            width_clamp = CW'(cfg_width);
        end
    end

    // An empty buffer picks up the current width; a line under way keeps its own.
    assign active_eff = (fill_reg == '0) ? width_clamp : active_reg;
    assign is_cut     = (in_char != SPACE_CHAR) && sp_seen_reg;
    assign line_done  = (idx_reg == active_reg - CW'(1));

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_EMIT);
    assign out_char     = (idx_reg < n_reg) ? buf_rd_data : SPACE_CHAR;
    assign out_line_end = line_done;
    assign out_text_end = line_done && final_reg;

    assign buf_wr_en   = (state_reg == S_APPEND);
    assign buf_wr_addr = head_reg + AW'(fill_reg);
    assign buf_wr_data = char_reg;
    assign buf_rd_en   = (state_reg == S_READ) || (state_reg == S_EMIT && out_ready);
    assign buf_rd_addr = head_reg + AW'(idx_next);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        head_next    = head_reg;
        sp_pos_next  = sp_pos_reg;
        sp_seen_next = sp_seen_reg;
        active_next  = active_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        final_next   = final_reg;
        cut_next     = cut_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    char_next   = in_char;
                    last_next   = in_last;
                    active_next = active_eff;
                    final_next  = 1'b0;
                    cut_next    = is_cut;
                    n_next      = is_cut ? CW'(sp_pos_reg) : fill_reg;
                    idx_next    = '0;
                    state_next  = (fill_reg >= active_eff) ? S_READ : S_APPEND;
                end
            end
            S_READ: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_ready) begin
                    if (line_done) begin
                        idx_next     = '0;
                        sp_seen_next = 1'b0;
                        sp_pos_next  = '0;
                        if (final_reg) begin
                            fill_next  = '0;
                            state_next = S_IDLE;
                        end else begin
                            // The tail after the cut holds no space: the cut took the last one.
                            if (cut_reg) begin
                                head_next = head_reg + sp_pos_reg + AW'(1);
                                fill_next = fill_reg - CW'(sp_pos_reg) - CW'(1);
                            end else begin
                                fill_next   = '0;
                                active_next = width_clamp;
                            end
                            state_next = S_APPEND;
                        end
                    end else begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            S_APPEND: begin
                fill_next = fill_reg + CW'(1);
                if (char_reg == SPACE_CHAR) begin
                    sp_seen_next = 1'b1;
                    sp_pos_next  = AW'(fill_reg);
                end
                if (last_reg) begin
                    final_next = 1'b1;
                    n_next     = fill_reg + CW'(1);
                    idx_next   = '0;
                    state_next = S_READ;
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            head_reg    <= '0;
            sp_pos_reg  <= '0;
            sp_seen_reg <= 1'b0;
            active_reg  <= CW'(LINE_MAX);
            idx_reg     <= '0;
            final_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            head_reg    <= head_next;
            sp_pos_reg  <= sp_pos_next;
            sp_seen_reg <= sp_seen_next;
            active_reg  <= active_next;
            idx_reg     <= idx_next;
            final_reg   <= final_next;
        end
        char_reg <= char_next;
        last_reg <= last_next;
        n_reg    <= n_next;
        cut_reg  <= cut_next;
    end

endmodule

// File: design/greedy_word_wrap_top.sv
// Greedy fixed-width word wrapper: takes one text byte per word and sends
// lines of exactly the configured width, cut before the last space of a full
// line when the next byte is not a space, padded with spaces. A byte that
// neither meets a full line nor ends a text passes through the append state
// and back to idle. A byte that arrives at a full line or carries the end mark
// adds, for each line it releases (at most two), a buffer read setup state and
// then one output character per cycle while the sink is ready; the single read
// port of the line buffer and the one-character output register set this.
// The input is not ready while a byte is being worked on. The width register
// may be written only while the block is idle; 0 acts as 1 and values above
// LINE_MAX act as LINE_MAX, and a new width takes effect at the next empty line.
// Depends on gww_pkg, gww_buf and gww_seq.
module greedy_word_wrap_top
    import gww_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,   // width
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,    // [7:0] in_char
    input  logic              s_tlast,    // in_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,    // [7:0] out_char
    output logic              m_tlast,    // text_end
    output logic [0:0]        m_tuser     // [0] line_end
);

    localparam int AW = $clog2(LINE_MAX > 1 ? LINE_MAX : 2);

    logic [CFG_W-1:0]  width_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] rd_data;
    logic              line_end;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else if (cfg_valid) begin
            width_reg <= cfg_data;
        end
    end

    gww_seq #(
        .LINE_MAX (LINE_MAX)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_width    (width_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_char      (s_tdata),
        .in_last      (s_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_char     (m_tdata),
        .out_line_end (line_end),
        .out_text_end (m_tlast),
        .buf_wr_en    (wr_en),
        .buf_wr_addr  (wr_addr),
        .buf_wr_data  (wr_data),
        .buf_rd_en    (rd_en),
        .buf_rd_addr  (rd_addr),
        .buf_rd_data  (rd_data)
    );

    gww_buf #(
        .AW (AW)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tuser = line_end;

endmodule

// File: design/gww_check.sv
// Port-level checker of the word wrapper, bound to greedy_word_wrap_top.
// Depends on gww_pkg and greedy_word_wrap_top_macros.svh.
`include "greedy_word_wrap_top_macros.svh"

module gww_check
    import gww_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [CHAR_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic [0:0]        m_tuser
);

    logic              out_stall;
    logic [CHAR_W+1:0] out_word;

    assign out_stall = m_tvalid && !m_tready;
    assign out_word  = {m_tuser, m_tlast, m_tdata};

    // A stalled output word holds.
    `GWW_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(out_word))

    // Input and output never open together: one byte at a time.
    `GWW_ASSERT_SAME(a_one_side, aclk, aresetn, 1'b1, !(s_tready && m_tvalid))

    // End of text always falls on the end of a line.
    `GWW_ASSERT_SAME(a_text_on_line, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0])

    // Every accepted byte keeps the input closed in the next cycle.
    `GWW_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind greedy_word_wrap_top gww_check u_check (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for greedy_word_wrap_top: streams text through the wrapper
// under several line widths and checks every output character against a predictor.
// Depends on gww_pkg and the RTL of the word wrapper.
module tb_top;
    import gww_pkg::*;

    localparam int LINE_MAX   = LINE_MAX_DEF;
    localparam int DRAIN_WAIT = 100;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_byte_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              line_end;
        logic              text_end;
    } line_char_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata   = '0;    // [7:0] in_char
    logic              s_tlast   = 1'b0;  // in_last
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [CHAR_W-1:0] m_tdata;           // [7:0] out_char
    logic              m_tlast;           // text_end
    logic [0:0]        m_tuser;           // [0] line_end

    greedy_word_wrap_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    text_byte_t text_q[$];
    line_char_t line_q[$];

    // predictor state
    logic [CHAR_W-1:0] wrap_buf[LINE_MAX];
    int unsigned       wrap_fill      = 0;
    int unsigned       wrap_space_pos = 0;
    bit                wrap_space_seen = 1'b0;
    logic [CFG_W-1:0]  width_reg      = WIDTH_RESET;
    int unsigned       wrap_width     = LINE_MAX;

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned chars_seen   = 0;
    int unsigned lines_seen   = 0;
    int unsigned texts_seen   = 0;
    int unsigned cut_lines    = 0;
    int unsigned errors       = 0;

    bit          calm      = 1'b0;
    bit          hold_arm  = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned stall_left = 0;

    int unsigned text_left = 0;
    int unsigned word_left = 0;

    function automatic int unsigned eff_width(input logic [CFG_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > LINE_MAX)
            return LINE_MAX;
        return 32'(w);
    endfunction

    task automatic emit_line(input int unsigned n, input int unsigned w, input bit ends);
        line_char_t c;
        for (int unsigned i = 0; i < w; i++) begin
            c.ch       = (i < n) ? wrap_buf[i] : SPACE_CHAR;
            c.line_end = (i + 1 == w);
            c.text_end = ends && (i + 1 == w);
            line_q.push_back(c);
        end
    endtask

    task automatic rescan_spaces();
        wrap_space_seen = 1'b0;
        wrap_space_pos  = 0;
        for (int unsigned i = 0; i < wrap_fill; i++) begin
            if (wrap_buf[i] == SPACE_CHAR) begin
                wrap_space_seen = 1'b1;
                wrap_space_pos  = i;
            end
        end
    endtask

    task automatic wrap_byte(input logic [CHAR_W-1:0] ch, input logic last);
        int unsigned cut_pos;
        int unsigned rest;
        if (wrap_fill == 0)
            wrap_width = eff_width(width_reg);
        if (wrap_fill >= wrap_width) begin
            if (ch != SPACE_CHAR && wrap_space_seen) begin
                // cut before the last space, drop it, carry the tail
                cut_pos = wrap_space_pos;
                rest    = wrap_fill - cut_pos - 1;
                emit_line(cut_pos, wrap_width, 1'b0);
                for (int unsigned i = 0; i < rest; i++)
                    wrap_buf[i] = wrap_buf[cut_pos + 1 + i];
                wrap_fill = rest;
                rescan_spaces();
                cut_lines++;
            end else begin
                emit_line(wrap_fill, wrap_width, 1'b0);
                wrap_fill       = 0;
                wrap_space_seen = 1'b0;
                wrap_space_pos  = 0;
                wrap_width      = eff_width(width_reg);
            end
        end
        if (wrap_fill < LINE_MAX) begin
            wrap_buf[wrap_fill] = ch;
            if (ch == SPACE_CHAR) begin
                wrap_space_seen = 1'b1;
                wrap_space_pos  = wrap_fill;
            end
            wrap_fill++;
        end
        if (last) begin
            emit_line(wrap_fill, wrap_width, 1'b1);
            wrap_fill       = 0;
            wrap_space_seen = 1'b0;
            wrap_space_pos  = 0;
        end
    endtask

    // sender
    always @(posedge aclk) begin : drive_text
        text_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (text_q.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
                nxt = text_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.ch;
                s_tlast  <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off when armed
    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (hold_arm && !hold_done) begin
            m_tready   <= 1'b0;
            stall_left <= 400;
            hold_done  <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 31);
        end
    end

    // predict on every accepted word, then check the output side
    always @(posedge aclk) begin : check_lines
        line_char_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                width_reg = cfg_data;
            if (s_tvalid && s_tready) begin
                wrap_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (m_tvalid && m_tready) begin
                chars_seen++;
                if (m_tuser[0])
                    lines_seen++;
                if (m_tlast)
                    texts_seen++;
                if (line_q.size() == 0) begin
                    $error("unexpected output word: out_char %0d line_end %0d text_end %0d",
                           m_tdata, m_tuser[0], m_tlast);
                    errors++;
                end else begin
                    want = line_q.pop_front();
                    if (m_tdata !== want.ch) begin
                        $error("out_char: expected %0d, got %0d", want.ch, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== want.line_end) begin
                        $error("line_end: expected %0d, got %0d", want.line_end, m_tuser[0]);
                        errors++;
                    end
                    if (m_tlast !== want.text_end) begin
                        $error("text_end: expected %0d, got %0d", want.text_end, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_byte(input logic [CHAR_W-1:0] ch, input logic last);
        text_byte_t b;
        b.ch   = ch;
        b.last = last;
        text_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1);
    endtask

    // wait out queued bytes and results, then any byte still being worked on
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || line_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // words of letters with random gaps and stray random bytes; texts may run across a width change
    task automatic queue_words(input int n, input int unsigned w, input bit finish);
        logic [CHAR_W-1:0] ch;
        logic              last;
        for (int i = 0; i < n; i++) begin
            if (text_left == 0)
                text_left = ($urandom_range(1) == 0) ? $urandom_range(1, w + 2)
                                                     : $urandom_range(w, 4 * w + 8);
            if (word_left == 0) begin
                ch        = SPACE_CHAR;
                word_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, w + 2);
            end else begin
                ch = 8'h61 + 8'($urandom_range(25));
                word_left--;
            end
            if ($urandom_range(19) == 0)
                ch = 8'($urandom_range(255));
            text_left--;
            last = (text_left == 0) || (finish && i == n - 1);
            if (last)
                text_left = 0;
            push_byte(ch, last);
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] phase_widths[8];
        logic [CFG_W-1:0] w_new;
        phase_widths = '{6'd0, 6'd63, 6'd1, 6'd32, 6'd5, 6'd12, 6'd2, 6'd31};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset width: single bytes that end a text, byte extremes
        push_byte(8'h61, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        wait_drained();

        // narrow lines: cut, cut at the first position, space lookahead,
        // full buffer at the final byte
        write_width(6'd4);
        push_str("ab cde");
        push_str(" abcde");
        push_str("abcd ");
        push_str("abcd");

        for (int ph = 0; ph < 10; ph++) begin
            wait_drained();
            w_new = (ph < 8) ? phase_widths[ph] : 6'($urandom_range(2, 31));
            write_width(w_new);
            calm     = (ph == 4);
            hold_arm = (ph == 3);
            queue_words(40, eff_width(w_new), ph == 9);
        end
        wait_drained();

        $display("run covered %0d input bytes, %0d output characters in %0d lines",
                 bytes_taken, chars_seen, lines_seen);
        $display("%0d texts ended, %0d lines cut at a space, widths 0 to 63 written",
                 texts_seen, cut_lines);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout: %0d of %0d bytes taken, %0d characters pending",
                 bytes_taken, bytes_queued, line_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: greedy_word_wrap_top.f
+incdir+design
design/gww_pkg.sv
design/gww_buf.sv
design/gww_seq.sv
design/greedy_word_wrap_top.sv
design/gww_check.sv
sim/tb_top.sv
